### rtl/apg_pkg.sv
// apg_pkg: shared types, constants and the CORDIC angle table of the arc point generator.
// Depends on nothing; every rtl module refers to it by scoped names.
`default_nettype none
package apg_pkg;

  localparam int MAX_SEGMENTS_DEF = 63;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int TRIG_W           = 34;
  localparam int SPAN_W           = 33;
  localparam int SEG_W            = 6;
  localparam int IDX_W            = 16;
  localparam int FIFO_DEPTH       = 4;
  localparam int TRIG_SHIFT       = 30;

  localparam logic signed [TRIG_W-1:0] PI_Q27      = 34'sd421657428;
  localparam logic signed [TRIG_W-1:0] TWO_PI_Q27  = 34'sd843314857;
  localparam logic signed [TRIG_W-1:0] FOUR_PI_Q27 = 34'sd1686629714;
  localparam logic signed [TRIG_W-1:0] HALF_PI_Q27 = 34'sd210828714;
  localparam logic signed [TRIG_W-1:0] GAIN_Q30    = 34'sd652032874;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_DIV,
    FRONT_GEN
  } front_state_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [31:0]        cz;
    logic [30:0]        radius;
    logic [IDX_W-1:0]   node;
    logic               last;
  } side_t;

  typedef struct packed {
    logic signed [31:0] angle;
    side_t              side;
  } point_req_t;

  function automatic logic signed [TRIG_W-1:0] atan_q30(input int i);
    logic signed [TRIG_W-1:0] v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      24: v = 34'sd64;
      25: v = 34'sd32;
      26: v = 34'sd16;
      27: v = 34'sd8;
      28: v = 34'sd4;
      29: v = 34'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/apg_fifo.sv
// apg_fifo: short queue of point words between the front and the back.
// Depends on apg_pkg for the word type and depth.
`default_nettype none
module apg_fifo (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  apg_pkg::point_req_t wdata,
  input  wire                pop,
  output apg_pkg::point_req_t rdata,
  output logic               full,
  output logic               empty
);
  localparam int AW = $clog2(apg_pkg::FIFO_DEPTH);

  apg_pkg::point_req_t mem [0:apg_pkg::FIFO_DEPTH-1];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(apg_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/apg_front.sv
// apg_front: takes a request, divides the angle span by the segment count
// and issues one point word per point into the queue. Depends on apg_pkg.
`default_nettype none
module apg_front #(
  parameter int MAX_SEGMENTS = apg_pkg::MAX_SEGMENTS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire signed [31:0]   center_x,
  input  wire signed [31:0]   center_y,
  input  wire signed [31:0]   center_z,
  input  wire signed [31:0]   angle_start,
  input  wire signed [31:0]   angle_end,
  input  wire [30:0]          radius,
  input  wire [5:0]           segments,
  input  wire [15:0]          base_index,
  input  wire                 full,
  output logic                push,
  output apg_pkg::point_req_t wdata
);
  localparam int SW = apg_pkg::SPAN_W;
  localparam int NW = apg_pkg::SEG_W;

  apg_pkg::front_state_t state, state_next;
  logic [NW-1:0]      cnt;
  logic [SW-1:0]      dq;
  logic [NW-1:0]      rem;
  logic [NW-1:0]      nseg;
  logic [NW-1:0]      k;
  logic [SW-1:0]      qacc;
  logic [NW-1:0]      racc;
  logic               span_neg;
  logic signed [31:0] a0;
  apg_pkg::side_t     item;

  logic               accept;
  logic [NW-1:0]      n_in;
  logic signed [SW-1:0] span;
  logic [NW:0]        rem_sh;
  logic               qbit;
  logic [NW:0]        rsum;
  logic signed [SW:0] ang;

  function automatic logic [15:0] IDX_EXT(input logic [NW-1:0] v);
    return 16'(v);
  endfunction

  assign accept = start && !busy;
  assign n_in   = (segments > NW'(MAX_SEGMENTS)) ? NW'(MAX_SEGMENTS) : segments;
  assign span   = SW'(angle_end) - SW'(angle_start);
  assign rem_sh = {rem, dq[SW-1]};
  assign qbit   = (rem_sh >= {1'b0, nseg});
  assign rsum   = {1'b0, racc} + {1'b0, rem};
  assign ang    = (SW+1)'(a0) + (span_neg ? -$signed({1'b0, qacc}) : $signed({1'b0, qacc}));

  always_comb begin
    state_next = state;
    case (state)
      apg_pkg::FRONT_IDLE: if (accept) begin
        state_next = (n_in == '0) ? apg_pkg::FRONT_GEN : apg_pkg::FRONT_DIV;
      end
      apg_pkg::FRONT_DIV: if (cnt == NW'(SW-1)) begin
        state_next = apg_pkg::FRONT_GEN;
      end
      apg_pkg::FRONT_GEN: if (!full && k == nseg) begin
        state_next = apg_pkg::FRONT_IDLE;
      end
      default: state_next = apg_pkg::FRONT_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != apg_pkg::FRONT_IDLE);
    push       = (state == apg_pkg::FRONT_GEN) && !full;
    wdata.angle = ang[31:0];
    wdata.side  = item;
    wdata.side.node = item.node + IDX_EXT(k);
    wdata.side.last = (k == nseg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apg_pkg::FRONT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      apg_pkg::FRONT_IDLE: if (accept) begin
        a0          <= angle_start;
        span_neg    <= span[SW-1];
        dq          <= span[SW-1] ? SW'(-span) : SW'(span);
        rem         <= '0;
        nseg        <= n_in;
        cnt         <= '0;
        k           <= '0;
        qacc        <= '0;
        racc        <= '0;
        item.cx     <= center_x;
        item.cy     <= center_y;
        item.cz     <= center_z;
        item.radius <= radius;
        item.node   <= base_index;
        item.last   <= 1'b0;
      end
      apg_pkg::FRONT_DIV: begin
        rem <= qbit ? NW'(rem_sh - {1'b0, nseg}) : rem_sh[NW-1:0];
        dq  <= {dq[SW-2:0], qbit};
        cnt <= cnt + 1'b1;
      end
      apg_pkg::FRONT_GEN: if (!full) begin
        k <= k + 1'b1;
        if (rsum >= {1'b0, nseg}) begin
          racc <= NW'(rsum - {1'b0, nseg});
          qacc <= qacc + dq + 1'b1;
        end else begin
          racc <= rsum[NW-1:0];
          qacc <= qacc + dq;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### rtl/apg_back.sv
// apg_back: angle reduction, pipelined CORDIC, radius scaling and centre offset.
// Depends on apg_pkg. Takes one queue word per cycle and never stalls.
`default_nettype none
module apg_back #(
  parameter int CORDIC_STEPS = apg_pkg::CORDIC_STEPS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  apg_pkg::point_req_t in_word,
  output logic                strobe,
  output logic [15:0]         node_index,
  output logic signed [31:0]  point_x,
  output logic signed [31:0]  point_y,
  output logic signed [31:0]  point_z,
  output logic                last_point
);
  localparam int TW = apg_pkg::TRIG_W;

  logic                 va, vb, vn;
  logic signed [TW-1:0] ra;
  apg_pkg::side_t       sa, sb, sn;

  logic                 cv  [0:CORDIC_STEPS];
  logic signed [TW-1:0] cxs [0:CORDIC_STEPS];
  logic signed [TW-1:0] cys [0:CORDIC_STEPS];
  logic signed [TW-1:0] czs [0:CORDIC_STEPS];
  logic                 cng [0:CORDIC_STEPS];
  apg_pkg::side_t       csd [0:CORDIC_STEPS];

  logic signed [TW-1:0] cosn, sinn;
  logic signed [65:0]   px, py;

  logic signed [TW-1:0] a_in, a_mod, a_w, a_f;
  logic                 neg_f;

  always_comb begin
    a_in = TW'(in_word.angle);
    if (a_in >= apg_pkg::FOUR_PI_Q27)       a_mod = a_in - apg_pkg::FOUR_PI_Q27;
    else if (a_in >= apg_pkg::TWO_PI_Q27)   a_mod = a_in - apg_pkg::TWO_PI_Q27;
    else if (a_in <= -apg_pkg::FOUR_PI_Q27) a_mod = a_in + apg_pkg::FOUR_PI_Q27;
    else if (a_in <= -apg_pkg::TWO_PI_Q27)  a_mod = a_in + apg_pkg::TWO_PI_Q27;
    else                                    a_mod = a_in;
  end

  always_comb begin
    a_w = ra;
    if (a_w > apg_pkg::PI_Q27)  a_w = a_w - apg_pkg::TWO_PI_Q27;
    if (a_w < -apg_pkg::PI_Q27) a_w = a_w + apg_pkg::TWO_PI_Q27;
    neg_f = 1'b0;
    a_f   = a_w;
    if (a_w > apg_pkg::HALF_PI_Q27) begin
      a_f   = a_w - apg_pkg::PI_Q27;
      neg_f = 1'b1;
    end else if (a_w < -apg_pkg::HALF_PI_Q27) begin
      a_f   = a_w + apg_pkg::PI_Q27;
      neg_f = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      cv[0] <= 1'b0;
    end else begin
      va    <= in_valid;
      cv[0] <= va;
    end
  end

  always_ff @(posedge clk) begin
    ra     <= a_mod;
    sa     <= in_word.side;
    cxs[0] <= apg_pkg::GAIN_Q30;
    cys[0] <= '0;
    czs[0] <= a_f <<< 3;
    cng[0] <= neg_f;
    csd[0] <= sa;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= cv[i];
      end
    end
    always_ff @(posedge clk) begin
      if (czs[i] >= 0) begin
        cxs[i+1] <= cxs[i] - (cys[i] >>> i);
        cys[i+1] <= cys[i] + (cxs[i] >>> i);
        czs[i+1] <= czs[i] - apg_pkg::atan_q30(i);
      end else begin
        cxs[i+1] <= cxs[i] + (cys[i] >>> i);
        cys[i+1] <= cys[i] - (cxs[i] >>> i);
        czs[i+1] <= czs[i] + apg_pkg::atan_q30(i);
      end
      cng[i+1] <= cng[i];
      csd[i+1] <= csd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb     <= 1'b0;
      vn     <= 1'b0;
      strobe <= 1'b0;
    end else begin
      vb     <= cv[CORDIC_STEPS];
      vn     <= vb;
      strobe <= vn;
    end
  end

  always_ff @(posedge clk) begin
    cosn <= cng[CORDIC_STEPS] ? -cxs[CORDIC_STEPS] : cxs[CORDIC_STEPS];
    sinn <= cng[CORDIC_STEPS] ? -cys[CORDIC_STEPS] : cys[CORDIC_STEPS];
    sb   <= csd[CORDIC_STEPS];
    px   <= 66'($signed({1'b0, sb.radius}) * cosn);
    py   <= 66'($signed({1'b0, sb.radius}) * sinn);
    sn   <= sb;
    point_x    <= sn.cx + 32'((px + (66'sd1 <<< (apg_pkg::TRIG_SHIFT-1))) >>> apg_pkg::TRIG_SHIFT);
    point_y    <= sn.cy + 32'((py + (66'sd1 <<< (apg_pkg::TRIG_SHIFT-1))) >>> apg_pkg::TRIG_SHIFT);
    point_z    <= sn.cz;
    node_index <= sn.node;
    last_point <= sn.last;
  end
endmodule
`default_nettype wire

### rtl/arc_point_generator.sv
// arc_point_generator: top level of the arc point generator.
// Depends on apg_pkg, apg_front, apg_fifo and apg_back.
//
// channel  | ports                                               | handshake
// request  | center_x/y/z angle_start angle_end radius segments  | start & !busy
//          | base_index                                          |
// point    | node_index point_x point_y point_z last_point       | strobe, one cycle
//
// A request runs the span division (skipped for zero segments), then issues one point word
// per cycle while the queue is not full, for segments+1 points (segments capped at
// MAX_SEGMENTS); busy stays high until the last word enters the queue. Reset is
// synchronous and clears all control state. Results cannot be stalled.
`default_nettype none
module arc_point_generator #(
  parameter int MAX_SEGMENTS = apg_pkg::MAX_SEGMENTS_DEF,
  parameter int CORDIC_STEPS = apg_pkg::CORDIC_STEPS_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire signed [31:0]  center_x,
  input  wire signed [31:0]  center_y,
  input  wire signed [31:0]  center_z,
  input  wire signed [31:0]  angle_start,
  input  wire signed [31:0]  angle_end,
  input  wire [30:0]         radius,
  input  wire [5:0]          segments,
  input  wire [15:0]         base_index,
  output logic               strobe,
  output logic [15:0]        node_index,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic               last_point
);
  apg_pkg::point_req_t wdata, rdata;
  logic push, full, empty;

  apg_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
    .clk, .rst, .start, .busy,
    .center_x, .center_y, .center_z, .angle_start, .angle_end,
    .radius, .segments, .base_index,
    .full, .push, .wdata
  );

  apg_fifo u_fifo (
    .clk, .rst, .push, .wdata, .pop(!empty), .rdata, .full, .empty
  );

  apg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst, .in_valid(!empty), .in_word(rdata),
    .strobe, .node_index, .point_x, .point_y, .point_z, .last_point
  );
endmodule
`default_nettype wire
